[design/rpip_pkg.sv]
package rpip_pkg;

    // ASCII codes that steer the parser.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_BIN     = 8'h62;
    localparam logic [7:0] CH_OCT     = 8'h6F;
    localparam logic [7:0] CH_HEX     = 8'h78;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Radix codes as they appear on the result port.
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // Scan phase of the parser.
    typedef enum logic [2:0] {
        PH_SEEK   = 3'b001,
        PH_ZERO   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

endpackage

[design/radix_prefixed_integer_parser_core.sv]
// An accepted item is held in the stage register, and a result that it ends is then
// registered in the result register, from which it is shown on the output.
// Throughput: one character per cycle unless the output stalls; the single accumulate
// step (shift-add) per character sets the rate, and a stall holds the one staged item.
// Reset (rst_n low, asynchronous) returns the parser to seeking with a cleared
// accumulator and empties both the stage and the result registers.
module radix_prefixed_integer_parser_core #(
    parameter int ACC_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         character,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] value,
    output logic [1:0]         radix_code
);

    // Stage register that holds the accepted character.
    logic                    ch_vld_reg;
    logic [7:0]              ch_reg;

    // Parser state.
    rpip_pkg::phase_t        phase_reg, phase_next;
    logic [1:0]              base_reg, base_next;
    logic                    neg_reg, neg_next;
    logic [ACC_WIDTH-1:0]    acc_reg, acc_next;

    // Result register.
    logic                    out_vld_reg;
    logic signed [63:0]      value_reg, value_next;
    logic [1:0]              radix_reg;

    logic                    advance;
    logic                    emit;
    logic [1:0]              eff_base;
    logic                    run_digit;
    logic [3:0]              digit;
    logic                    is_num;
    logic                    is_alpha;
    logic                    digit_ok;
    logic [ACC_WIDTH-1:0]    acc_scaled;
    logic [ACC_WIDTH-1:0]    signed_acc;

    // The stage moves on whenever the result register is free or is being taken.
    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = !ch_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign value     = value_reg;
    assign radix_code = radix_reg;

    // Digit decode of the staged character, independent of the base.
    always_comb
    begin
        is_num   = (ch_reg >= rpip_pkg::CH_ZERO) && (ch_reg <= rpip_pkg::CH_NINE);
        is_alpha = 1'b0;
        digit    = 4'd0;
        if (is_num)
        begin
            digit = 4'(ch_reg - rpip_pkg::CH_ZERO);
        end
        else if ((ch_reg >= rpip_pkg::CH_LOWER_A) && (ch_reg <= rpip_pkg::CH_LOWER_F))
        begin
            is_alpha = 1'b1;
            digit    = 4'(ch_reg - rpip_pkg::CH_LOWER_A + 8'd10);
        end
        else if ((ch_reg >= rpip_pkg::CH_UPPER_A) && (ch_reg <= rpip_pkg::CH_UPPER_F))
        begin
            is_alpha = 1'b1;
            digit    = 4'(ch_reg - rpip_pkg::CH_UPPER_A + 8'd10);
        end
    end

    // Check the digit against the base in effect for this character.
    always_comb
    begin
        unique case (eff_base)
            rpip_pkg::RADIX_BIN: digit_ok = is_num && (digit < 4'd2);
            rpip_pkg::RADIX_OCT: digit_ok = is_num && (digit < 4'd8);
            rpip_pkg::RADIX_DEC: digit_ok = is_num;
            default:             digit_ok = is_num || is_alpha;
        endcase
    end

    // Multiply by the base with shifts; all bases are sums of at most two shifts.
    always_comb
    begin
        unique case (eff_base)
            rpip_pkg::RADIX_BIN: acc_scaled = acc_reg << 1;
            rpip_pkg::RADIX_OCT: acc_scaled = acc_reg << 3;
            rpip_pkg::RADIX_DEC: acc_scaled = (acc_reg << 3) + (acc_reg << 1);
            default:             acc_scaled = acc_reg << 4;
        endcase
    end

    // Apply the sign only to negative decimal numbers, then widen to the port.
    assign signed_acc = (neg_reg && (eff_base == rpip_pkg::RADIX_DEC))
                        ? (ACC_WIDTH'(0) - acc_reg) : acc_reg;
    assign value_next = 64'($signed(signed_acc));

    // Next parser state for the staged character.
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        run_digit  = 1'b0;
        eff_base   = base_reg;
        unique case (phase_reg)
            rpip_pkg::PH_SEEK:
            begin
                if (ch_reg == rpip_pkg::CH_ZERO)
                begin
                    acc_next   = '0;
                    phase_next = rpip_pkg::PH_ZERO;
                end
                else if (ch_reg == rpip_pkg::CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    base_next  = rpip_pkg::RADIX_DEC;
                    acc_next   = '0;
                    phase_next = rpip_pkg::PH_DIGITS;
                end
                else if ((ch_reg >= rpip_pkg::CH_ONE) && (ch_reg <= rpip_pkg::CH_NINE))
                begin
                    neg_next   = 1'b0;
                    base_next  = rpip_pkg::RADIX_DEC;
                    acc_next   = ACC_WIDTH'(digit);
                    phase_next = rpip_pkg::PH_DIGITS;
                end
            end
            rpip_pkg::PH_ZERO:
            begin
                phase_next = rpip_pkg::PH_DIGITS;
                if (ch_reg == rpip_pkg::CH_BIN)
                begin
                    base_next = rpip_pkg::RADIX_BIN;
                end
                else if (ch_reg == rpip_pkg::CH_OCT)
                begin
                    base_next = rpip_pkg::RADIX_OCT;
                end
                else if (ch_reg == rpip_pkg::CH_HEX)
                begin
                    base_next = rpip_pkg::RADIX_HEX;
                end
                else
                begin
                    // A lone zero: this character is read as a decimal digit.
                    base_next = rpip_pkg::RADIX_DEC;
                    eff_base  = rpip_pkg::RADIX_DEC;
                    run_digit = 1'b1;
                end
            end
            default:
            begin
                run_digit = 1'b1;
            end
        endcase

        // Accumulate a valid digit, or end the number on the first invalid one.
        if (run_digit)
        begin
            if (digit_ok)
            begin
                acc_next = acc_scaled + ACC_WIDTH'(digit);
            end
            else
            begin
                emit       = 1'b1;
                phase_next = rpip_pkg::PH_SEEK;
                base_next  = rpip_pkg::RADIX_DEC;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= rpip_pkg::PH_SEEK;
            base_reg    <= rpip_pkg::RADIX_DEC;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                ch_vld_reg <= in_valid;
            end
            if (ch_vld_reg && advance)
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
            if (advance)
            begin
                out_vld_reg <= ch_vld_reg && emit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= character;
        end
        if (ch_vld_reg && advance && emit)
        begin
            value_reg <= value_next;
            radix_reg <= eff_base;
        end
    end

    // A finished number always returns the parser to seeking.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ch_vld_reg && advance && emit) |=> (phase_reg == rpip_pkg::PH_SEEK))
    else $error("parser did not return to seeking after a result");

    // After a leading zero the number is still empty and positive.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rpip_pkg::PH_ZERO) |-> ((acc_reg == '0) && !neg_reg))
    else $error("leading zero phase with nonzero accumulator or sign");

    // A staged item that cannot move on stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ch_vld_reg && !advance) |=> (ch_vld_reg && $stable(ch_reg)))
    else $error("staged item lost while the output was stalled");

endmodule

[verif/parse_result_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the parser, predicts each parsed number from the
// accepted characters, and compares every accepted result in order.
module parse_result_checker #(
    parameter int ACC_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         character,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [63:0] value,
    input  logic [1:0]         radix_code,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         radix_code;
    } parsed_number_t;

    localparam logic [63:0] MAG_MASK = {64{1'b1}} >> (64 - ACC_WIDTH);

    // Shadow copy of the parser state.
    rpip_pkg::phase_t phase;
    logic [1:0]       base_code;
    logic             minus_seen;
    logic [63:0]      magnitude;

    parsed_number_t pending_numbers[$];

    function automatic logic [63:0] radix_of(input logic [1:0] code);
        case (code)
            rpip_pkg::RADIX_BIN: return 64'd2;
            rpip_pkg::RADIX_OCT: return 64'd8;
            rpip_pkg::RADIX_DEC: return 64'd10;
            default:             return 64'd16;
        endcase
    endfunction

    task automatic clear_number();
        phase      = rpip_pkg::PH_SEEK;
        base_code  = rpip_pkg::RADIX_DEC;
        minus_seen = 1'b0;
        magnitude  = '0;
    endtask

    // Advances the shadow state by one character and queues a number when
    // the character terminates one.
    task automatic take_char(input logic [7:0] c);
        int             digit;
        logic [63:0]    v;
        parsed_number_t num;
        if (phase == rpip_pkg::PH_SEEK)
        begin
            if (c == rpip_pkg::CH_ZERO)
            begin
                magnitude = '0;
                phase     = rpip_pkg::PH_ZERO;
            end
            else if (c == rpip_pkg::CH_MINUS)
            begin
                minus_seen = 1'b1;
                base_code  = rpip_pkg::RADIX_DEC;
                magnitude  = '0;
                phase      = rpip_pkg::PH_DIGITS;
            end
            else if (c >= rpip_pkg::CH_ONE && c <= rpip_pkg::CH_NINE)
            begin
                minus_seen = 1'b0;
                base_code  = rpip_pkg::RADIX_DEC;
                magnitude  = 64'(c - rpip_pkg::CH_ZERO) & MAG_MASK;
                phase      = rpip_pkg::PH_DIGITS;
            end
            return;
        end

        // A leading zero either picks a prefix or falls back to decimal, in
        // which case this character is read as a decimal digit below.
        if (phase == rpip_pkg::PH_ZERO)
        begin
            phase = rpip_pkg::PH_DIGITS;
            if (c == rpip_pkg::CH_BIN)
            begin
                base_code = rpip_pkg::RADIX_BIN;
                return;
            end
            if (c == rpip_pkg::CH_OCT)
            begin
                base_code = rpip_pkg::RADIX_OCT;
                return;
            end
            if (c == rpip_pkg::CH_HEX)
            begin
                base_code = rpip_pkg::RADIX_HEX;
                return;
            end
            base_code = rpip_pkg::RADIX_DEC;
        end

        digit = -1;
        if (c >= rpip_pkg::CH_ZERO && c <= rpip_pkg::CH_NINE)
            digit = int'(c - rpip_pkg::CH_ZERO);
        else if (c >= rpip_pkg::CH_LOWER_A && c <= rpip_pkg::CH_LOWER_F)
            digit = int'(c - rpip_pkg::CH_LOWER_A) + 10;
        else if (c >= rpip_pkg::CH_UPPER_A && c <= rpip_pkg::CH_UPPER_F)
            digit = int'(c - rpip_pkg::CH_UPPER_A) + 10;

        if (digit >= 0 && 64'(digit) < radix_of(base_code))
        begin
            magnitude = (magnitude * radix_of(base_code) + 64'(digit)) & MAG_MASK;
            return;
        end

        // Any other character ends the number; the sign applies to decimal only.
        v = magnitude & MAG_MASK;
        if (minus_seen && base_code == rpip_pkg::RADIX_DEC)
            v = (64'd0 - v) & MAG_MASK;
        if (ACC_WIDTH < 64 && v[ACC_WIDTH-1])
            v = v | ~MAG_MASK;
        num.value      = v;
        num.radix_code = base_code;
        pending_numbers.push_back(num);
        clear_number();
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        clear_number();
    end

    // Results are checked before the same edge's character is taken; a
    // character can never end a number that is already on the output.
    always @(posedge clk)
    begin
        parsed_number_t exp_num;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_numbers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected: value %h radix %0d",
                             $time, value, radix_code);
                end
                else
                begin
                    exp_num = pending_numbers.pop_front();
                    if (value !== exp_num.value)
                    begin
                        mismatches++;
                        $display("%0t: value expected %h actual %h",
                                 $time, exp_num.value, value);
                    end
                    if (radix_code !== exp_num.radix_code)
                    begin
                        mismatches++;
                        $display("%0t: radix_code expected %0d actual %0d",
                                 $time, exp_num.radix_code, radix_code);
                    end
                end
            end
            if (in_valid && in_ready)
                take_char(character);
            outstanding = pending_numbers.size();
        end
    end

endmodule

[verif/radix_prefixed_integer_parser_core_tb.sv]
`timescale 1ns / 100ps

module radix_prefixed_integer_parser_core_tb;

    localparam int CHAR_TARGET = 1350;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         character;
    logic               out_valid;
    logic               out_ready;
    logic signed [63:0] value;
    logic [1:0]         radix_code;

    int mismatches;
    int outstanding;
    int chars_sent;
    bit idle_on;
    bit hold_req;

    radix_prefixed_integer_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .radix_code (radix_code)
    );

    parse_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .character   (character),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .radix_code  (radix_code),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the parser hangs.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (60) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // Offers one character, with an optional gap first, and returns at the
    // falling edge after it is taken. Valid stays high for the next item.
    task automatic send_char(input logic [7:0] c);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid  = 1'b1;
        character = c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Sends one literal with random content and a random terminator, or a
    // burst of arbitrary bytes.
    task automatic send_literal();
        int          form;
        int          ndig;
        int          dv;
        logic [1:0]  code;
        logic [7:0]  c;
        logic [7:0]  top_digit;
        form = $urandom_range(0, 9);
        if (form >= 8)
        begin
            repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
            return;
        end
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 6);
        case (form)
            0:
            begin
                code = rpip_pkg::RADIX_BIN;
                send_char(rpip_pkg::CH_ZERO);
                send_char(rpip_pkg::CH_BIN);
            end
            1:
            begin
                code = rpip_pkg::RADIX_OCT;
                send_char(rpip_pkg::CH_ZERO);
                send_char(rpip_pkg::CH_OCT);
            end
            2, 3:
            begin
                code = rpip_pkg::RADIX_HEX;
                send_char(rpip_pkg::CH_ZERO);
                send_char(rpip_pkg::CH_HEX);
            end
            6:
            begin
                code = rpip_pkg::RADIX_DEC;
                send_char(rpip_pkg::CH_MINUS);
            end
            7:
            begin
                // Lone zero that turns into a decimal number.
                code = rpip_pkg::RADIX_DEC;
                send_char(rpip_pkg::CH_ZERO);
            end
            default:
            begin
                code = rpip_pkg::RADIX_DEC;
                send_char(rpip_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            end
        endcase

        repeat (ndig)
        begin
            case (code)
                rpip_pkg::RADIX_BIN: dv = $urandom_range(0, 1);
                rpip_pkg::RADIX_OCT: dv = $urandom_range(0, 7);
                rpip_pkg::RADIX_DEC: dv = $urandom_range(0, 9);
                default:             dv = $urandom_range(0, 15);
            endcase
            if (dv < 10)
                send_char(rpip_pkg::CH_ZERO + 8'(dv));
            else if ($urandom_range(0, 1) == 0)
                send_char(rpip_pkg::CH_LOWER_A + 8'(dv - 10));
            else
                send_char(rpip_pkg::CH_UPPER_A + 8'(dv - 10));
        end

        // Terminator: any byte that is not a digit of the base.
        top_digit = (code == rpip_pkg::RADIX_BIN) ? rpip_pkg::CH_ONE :
                    (code == rpip_pkg::RADIX_OCT) ? rpip_pkg::CH_ZERO + 8'd7 :
                    rpip_pkg::CH_NINE;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= rpip_pkg::CH_ZERO && c <= top_digit) ||
               (code == rpip_pkg::RADIX_HEX &&
                ((c >= rpip_pkg::CH_LOWER_A && c <= rpip_pkg::CH_LOWER_F) ||
                 (c >= rpip_pkg::CH_UPPER_A && c <= rpip_pkg::CH_UPPER_F))));
        send_char(c);
    endtask

    initial
    begin
        bit held;
        bit drained;
        int next_switch;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        character  = 8'h00;
        chars_sent = 0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        held       = 1'b0;
        drained    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: junk extremes, minus with no digits ended by a high byte,
        // hex prefix with no digits, octal and binary ended by an out-of-base
        // digit, lone zero, a short negative, and hex letters of both cases.
        send_char(8'hFF);
        send_char(8'h00);
        send_char(rpip_pkg::CH_MINUS);
        send_char(8'h80);
        send_text("0xg0o780b1209Z-9;0xaF/");

        // Random literals, with idling switched on and off in stretches.
        next_switch = chars_sent + 200;
        while (chars_sent < CHAR_TARGET)
        begin
            if (chars_sent >= next_switch)
            begin
                idle_on     = ($urandom_range(0, 3) != 0);
                next_switch = chars_sent + 200;
            end
            if (chars_sent >= CHAR_TARGET - 200)
                idle_on = 1'b0;
            if (!held && chars_sent >= 400)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!drained && chars_sent >= 800)
            begin
                drained  = 1'b1;
                in_valid = 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            send_literal();
        end
        in_valid = 1'b0;

        // Drain the remaining results, then allow for the pipeline depth.
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
